// ----- hdl/source_text_tokenizer_assert.svh -----
// ----------------------------------------------------------------------------
// source text tokenizer assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// property that must hold at every clock edge
`define STT_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define STT_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Token kinds, character codes, the token type and keyword lookup shared by
// the tokenizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

	localparam int MAX_TOKENS = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int FIELD_W    = 16;

	typedef logic [5:0] kind_t;

	// token kinds
	localparam kind_t K_EOF        = 6'd0;
	localparam kind_t K_NOT_PUNCT  = 6'd0;
	localparam kind_t K_IDENT      = 6'd1;
	localparam kind_t K_INT        = 6'd2;
	localparam kind_t K_FLOAT      = 6'd3;
	localparam kind_t K_STRING     = 6'd4;
	localparam kind_t K_LPAREN     = 6'd5;
	localparam kind_t K_RPAREN     = 6'd6;
	localparam kind_t K_LBRACE     = 6'd7;
	localparam kind_t K_RBRACE     = 6'd8;
	localparam kind_t K_COMMA      = 6'd9;
	localparam kind_t K_DOT        = 6'd10;
	localparam kind_t K_MINUS      = 6'd11;
	localparam kind_t K_PLUS       = 6'd12;
	localparam kind_t K_SEMI       = 6'd13;
	localparam kind_t K_COLON      = 6'd14;
	localparam kind_t K_SLASH      = 6'd15;
	localparam kind_t K_STAR       = 6'd16;
	localparam kind_t K_LESS       = 6'd17;
	localparam kind_t K_GREATER    = 6'd18;
	localparam kind_t K_EQUAL      = 6'd19;
	localparam kind_t K_BANG       = 6'd20;
	localparam kind_t K_RBRACKET   = 6'd21;
	localparam kind_t K_LBRACKET   = 6'd22;
	localparam kind_t K_AT         = 6'd23;
	localparam kind_t K_KW_FN      = 6'd24;
	localparam kind_t K_KW_LET     = 6'd25;
	localparam kind_t K_KW_USE     = 6'd26;
	localparam kind_t K_KW_IF      = 6'd27;
	localparam kind_t K_KW_ELSE    = 6'd28;
	localparam kind_t K_KW_WHILE   = 6'd29;
	localparam kind_t K_KW_RET     = 6'd30;
	localparam kind_t K_KW_FOR     = 6'd31;
	localparam kind_t K_KW_EXTERN  = 6'd32;
	localparam kind_t K_KW_INT     = 6'd33;
	localparam kind_t K_KW_FLOAT   = 6'd34;
	localparam kind_t K_KW_STRING  = 6'd35;
	localparam kind_t K_KW_VOID    = 6'd36;
	localparam kind_t K_UNKNOWN    = 6'd37;
	localparam kind_t K_UNTERM     = 6'd38;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		kind_t               kind;
		logic [FIELD_W-1:0]  start;
		logic [FIELD_W-1:0]  length;
		logic                last;
	} token_t;

	// status of the result queue toward the top level
	typedef struct packed {
		logic room;
		logic not_empty;
	} fifo_stat_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word_start(logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == 8'h5F);
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
	endfunction

	// single-byte punctuation, slash excluded
	function automatic kind_t punct_kind(logic [7:0] c);
		kind_t k;
		case (c)
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h7B:   k = K_LBRACE;
			8'h7D:   k = K_RBRACE;
			8'h2C:   k = K_COMMA;
			8'h2E:   k = K_DOT;
			8'h2D:   k = K_MINUS;
			8'h2B:   k = K_PLUS;
			8'h3B:   k = K_SEMI;
			8'h3A:   k = K_COLON;
			8'h2A:   k = K_STAR;
			8'h3C:   k = K_LESS;
			8'h3E:   k = K_GREATER;
			8'h3D:   k = K_EQUAL;
			8'h21:   k = K_BANG;
			8'h5D:   k = K_RBRACKET;
			8'h5B:   k = K_LBRACKET;
			8'h40:   k = K_AT;
			default: k = K_NOT_PUNCT;
		endcase
		return k;
	endfunction

	// first six word bytes, first byte in the top bits, unused bytes zero
	function automatic kind_t keyword_kind(logic [47:0] w, logic [3:0] n);
		kind_t k;
		k = K_IDENT;
		if (n == 4'd2 && w == {"fn", 32'h0})          k = K_KW_FN;
		else if (n == 4'd3 && w == {"let", 24'h0})    k = K_KW_LET;
		else if (n == 4'd3 && w == {"int", 24'h0})    k = K_KW_INT;
		else if (n == 4'd5 && w == {"float", 8'h0})   k = K_KW_FLOAT;
		else if (n == 4'd6 && w == "string")          k = K_KW_STRING;
		else if (n == 4'd3 && w == {"use", 24'h0})    k = K_KW_USE;
		else if (n == 4'd2 && w == {"if", 32'h0})     k = K_KW_IF;
		else if (n == 4'd4 && w == {"else", 16'h0})   k = K_KW_ELSE;
		else if (n == 4'd5 && w == {"while", 8'h0})   k = K_KW_WHILE;
		else if (n == 4'd3 && w == {"ret", 24'h0})    k = K_KW_RET;
		else if (n == 4'd3 && w == {"for", 24'h0})    k = K_KW_FOR;
		else if (n == 4'd6 && w == "extern")          k = K_KW_EXTERN;
		else if (n == 4'd4 && w == {"void", 16'h0})   k = K_KW_VOID;
		return k;
	endfunction

endpackage

// ----- hdl/stt_core.sv -----
// ----------------------------------------------------------------------------
// stt_core
// Lexer state and the single-pass step: one byte or end marker in, up to
// three tokens out, state updated in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_core import stt_pkg::*; #(
	parameter int POS_WIDTH   = 16,
	parameter int KEYWORD_MAX = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  char_byte,
	input  logic        is_end,
	output token_t      tok [MAX_TOKENS],
	output logic [1:0]  tok_n
);

	localparam int CW = $clog2(KEYWORD_MAX + 2);
	localparam int EW = (POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W;
	localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

	typedef enum logic [3:0] {
		M_IDLE, M_INT, M_INTDOT, M_FLOAT, M_IDENT, M_STRING, M_SLASH, M_COMMENT, M_CSTAR
	} mode_t;

	typedef logic [POS_WIDTH-1:0] pos_t;

	mode_t      mode_q, mode_d;
	pos_t       pos_q, pos_d;
	pos_t       begin_q, begin_d;
	pos_t       dot_q, dot_d;
	logic [7:0] word_q [KEYWORD_MAX];
	logic [7:0] word_d [KEYWORD_MAX];
	logic [CW-1:0] count_q, count_d;

	token_t     tok_c [MAX_TOKENS];
	logic [1:0] n_c;
	logic       run_idle;
	logic [47:0] w6;
	kind_t      ident_kind;

	mode_t      idle_mode;
	logic       idle_tok_v;
	kind_t      idle_kind;
	kind_t      pk;
	logic       idle_set_begin;
	pos_t       idle_begin;
	logic       idle_word;

	function automatic pos_t sat_inc(pos_t v);
		return (v == POS_MAX) ? v : v + pos_t'(1);
	endfunction

	function automatic pos_t span(pos_t from, pos_t upto);
		return (upto >= from) ? upto - from : '0;
	endfunction

	// saturate a position-wide value into a result field
	function automatic logic [FIELD_W-1:0] clamp(pos_t v);
		logic [EW-1:0] x;
		x = EW'(v);
		return (x > EW'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : x[FIELD_W-1:0];
	endfunction

	function automatic token_t mk(kind_t k, pos_t s, pos_t l);
		token_t t;
		t.kind   = k;
		t.start  = clamp(s);
		t.length = clamp(l);
		t.last   = 1'b0;
		return t;
	endfunction

	// keyword lookup on the first six buffered bytes
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			w6[47-8*k -: 8] = word_q[k];
		end
		ident_kind = keyword_kind(w6, 4'(count_q));
	end

	// what a byte does when no token is pending
	always_comb begin
		pk             = punct_kind(char_byte);
		idle_mode      = M_IDLE;
		idle_tok_v     = 1'b0;
		idle_kind      = pk;
		idle_set_begin = 1'b0;
		idle_begin     = pos_q;
		idle_word      = 1'b0;
		if (pk != K_NOT_PUNCT) begin
			idle_tok_v = 1'b1;
		end else if (char_byte == CH_SLASH) begin
			idle_mode      = M_SLASH;
			idle_set_begin = 1'b1;
		end else if (is_space(char_byte)) begin
			idle_mode = M_IDLE;
		end else if (is_digit(char_byte)) begin
			idle_mode      = M_INT;
			idle_set_begin = 1'b1;
		end else if (is_word_start(char_byte)) begin
			idle_mode      = M_IDENT;
			idle_set_begin = 1'b1;
			idle_word      = 1'b1;
		end else if (char_byte == CH_QUOTE) begin
			idle_mode      = M_STRING;
			idle_set_begin = 1'b1;
			idle_begin     = sat_inc(pos_q);
		end else begin
			idle_tok_v = 1'b1;
			idle_kind  = K_UNKNOWN;
		end
	end

	// step logic: pending token handling, then the idle action
	always_comb begin
		tok_c    = '{default: '0};
		n_c      = 2'd0;
		run_idle = 1'b0;
		mode_d   = mode_q;
		pos_d    = pos_q;
		begin_d  = begin_q;
		dot_d    = dot_q;
		word_d   = word_q;
		count_d  = count_q;
		if (is_end) begin
			// flush the pending token, then end of file and back to reset state
			case (mode_q)
				M_INT: begin
					tok_c[n_c] = mk(K_INT, begin_q, span(begin_q, pos_q));
					n_c = n_c + 2'd1;
				end
				M_INTDOT: begin
					tok_c[n_c] = mk(K_INT, begin_q, span(begin_q, dot_q));
					n_c = n_c + 2'd1;
					tok_c[n_c] = mk(K_DOT, dot_q, pos_t'(1));
					n_c = n_c + 2'd1;
				end
				M_FLOAT: begin
					tok_c[n_c] = mk(K_FLOAT, begin_q, span(begin_q, pos_q));
					n_c = n_c + 2'd1;
				end
				M_IDENT: begin
					tok_c[n_c] = mk(ident_kind, begin_q, span(begin_q, pos_q));
					n_c = n_c + 2'd1;
				end
				M_STRING: begin
					tok_c[n_c] = mk(K_UNTERM, begin_q, span(begin_q, pos_q));
					n_c = n_c + 2'd1;
				end
				M_SLASH: begin
					tok_c[n_c] = mk(K_SLASH, begin_q, pos_t'(1));
					n_c = n_c + 2'd1;
				end
				default: begin
				end
			endcase
			tok_c[n_c] = mk(K_EOF, pos_q, '0);
			n_c = n_c + 2'd1;
			mode_d  = M_IDLE;
			pos_d   = '0;
			begin_d = '0;
			dot_d   = '0;
			word_d  = '{default: '0};
			count_d = '0;
		end else begin
			pos_d = sat_inc(pos_q);
			case (mode_q)
				M_INT: begin
					if (char_byte == CH_DOT) begin
						mode_d = M_INTDOT;
						dot_d  = pos_q;
					end else if (!is_digit(char_byte)) begin
						tok_c[n_c] = mk(K_INT, begin_q, span(begin_q, pos_q));
						n_c = n_c + 2'd1;
						run_idle = 1'b1;
					end
				end
				M_INTDOT: begin
					if (is_digit(char_byte)) begin
						mode_d = M_FLOAT;
					end else begin
						tok_c[n_c] = mk(K_INT, begin_q, span(begin_q, dot_q));
						n_c = n_c + 2'd1;
						tok_c[n_c] = mk(K_DOT, dot_q, pos_t'(1));
						n_c = n_c + 2'd1;
						run_idle = 1'b1;
					end
				end
				M_FLOAT: begin
					if (!is_digit(char_byte)) begin
						tok_c[n_c] = mk(K_FLOAT, begin_q, span(begin_q, pos_q));
						n_c = n_c + 2'd1;
						run_idle = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_word_start(char_byte) || is_digit(char_byte)) begin
						for (int k = 0; k < KEYWORD_MAX; k++) begin
							if (count_q == CW'(k)) begin
								word_d[k] = char_byte;
							end
						end
						if (count_q <= CW'(KEYWORD_MAX)) begin
							count_d = count_q + CW'(1);
						end
					end else begin
						tok_c[n_c] = mk(ident_kind, begin_q, span(begin_q, pos_q));
						n_c = n_c + 2'd1;
						run_idle = 1'b1;
					end
				end
				M_STRING: begin
					if (char_byte == CH_QUOTE) begin
						tok_c[n_c] = mk(K_STRING, begin_q, span(begin_q, pos_q));
						n_c = n_c + 2'd1;
						mode_d = M_IDLE;
					end
				end
				M_SLASH: begin
					if (char_byte == CH_STAR) begin
						mode_d = M_COMMENT;
					end else begin
						tok_c[n_c] = mk(K_SLASH, begin_q, pos_t'(1));
						n_c = n_c + 2'd1;
						run_idle = 1'b1;
					end
				end
				M_COMMENT: begin
					if (char_byte == CH_STAR) begin
						mode_d = M_CSTAR;
					end
				end
				M_CSTAR: begin
					if (char_byte == CH_SLASH) begin
						mode_d = M_IDLE;
					end else if (char_byte != CH_STAR) begin
						mode_d = M_COMMENT;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase
			if (run_idle) begin
				mode_d = idle_mode;
				if (idle_tok_v) begin
					tok_c[n_c] = mk(idle_kind, pos_q, pos_t'(1));
					n_c = n_c + 2'd1;
				end
				if (idle_set_begin) begin
					begin_d = idle_begin;
				end
				if (idle_word) begin
					word_d    = '{default: '0};
					word_d[0] = char_byte;
					count_d   = CW'(1);
				end
			end
		end
		// mark the final token of this step
		if (n_c != 2'd0) begin
			tok_c[n_c - 2'd1].last = 1'b1;
		end
	end

	assign tok   = tok_c;
	assign tok_n = step ? n_c : 2'd0;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			dot_q   <= '0;
			word_q  <= '{default: '0};
			count_q <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			dot_q   <= dot_d;
			word_q  <= word_d;
			count_q <= count_d;
		end
	end

endmodule

// ----- hdl/stt_fifo.sv -----
// ----------------------------------------------------------------------------
// stt_fifo
// Result queue: takes up to three tokens per cycle, hands out one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_fifo import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  token_t      wr_tok [MAX_TOKENS],
	input  logic [1:0]  wr_n,
	input  logic        pop,
	output token_t      head,
	output fifo_stat_t  stat
);

	localparam int PW   = $clog2(FIFO_DEPTH);
	localparam int CNTW = $clog2(FIFO_DEPTH + 1);

	token_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CNTW-1:0] cnt_q;

	// entry storage, written in order from the write pointer
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_TOKENS; k++) begin
			if (2'(k) < wr_n) begin
				mem_q[wptr_q + PW'(k)] <= wr_tok[k];
			end
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + PW'(wr_n);
			rptr_q <= rptr_q + PW'(pop);
			cnt_q  <= cnt_q + CNTW'(wr_n) - CNTW'(pop);
		end
	end

	// room for a worst-case step, judged without the current pop
	assign stat.room      = cnt_q <= CNTW'(FIFO_DEPTH - MAX_TOKENS);
	assign stat.not_empty = cnt_q != '0;
	assign head           = mem_q[rptr_q];

endmodule

// ----- hdl/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte per request on the src channel, tokens
// (kind, start offset, length, last_of_run) out on the tok channel.
// A request with is_end set flushes the pending token, sends end of file and
// returns the lexer to offset 0 for the next source.
// A request is registered in the input stage (valid_s1, char_s1, end_s1),
// lexed from there into the queue, and its tokens leave from the queue head.
// Throughput: one byte per cycle while src_stall is low. Tokens leave one per
// cycle while tok_stall is low, through an eight-entry queue that absorbs a
// byte that causes two or three tokens.
// src_stall rises while the registered byte waits for three free queue
// slots, so a tok_stall held long enough backs up into the src channel.
// A stalled token stays on the tok ports unchanged.
// Reset clears the lexer state and empties the queue; no request is
// pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_text_tokenizer import stt_pkg::*; #(
	parameter int POS_WIDTH   = 16,
	parameter int KEYWORD_MAX = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  char_byte,
	input  logic        is_end,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [5:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        end_s1;
	logic        step;
	token_t      tok [MAX_TOKENS];
	logic [1:0]  tok_n;
	token_t      head;
	fifo_stat_t  stat;
	logic        pop;

	// input register advances when the queue can take a worst-case step
	assign step      = valid_s1 & stat.room;
	assign src_stall = valid_s1 & ~stat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			char_s1 <= char_byte;
			end_s1  <= is_end;
		end
	end

	stt_core #(
		.POS_WIDTH   (POS_WIDTH),
		.KEYWORD_MAX (KEYWORD_MAX)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_byte (char_s1),
		.is_end    (end_s1),
		.tok       (tok),
		.tok_n     (tok_n)
	);

	stt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_tok (tok),
		.wr_n   (tok_n),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	// result channel
	assign tok_valid    = stat.not_empty;
	assign pop          = stat.not_empty & ~tok_stall;
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

endmodule

// ----- hdl/stt_checker.sv -----
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the token channel, bound to the tokenizer top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "source_text_tokenizer_assert.svh"

module stt_checker import stt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_stall,
	input logic [5:0]  token_kind,
	input logic [15:0] token_start,
	input logic [15:0] token_length,
	input logic        last_of_run
);

	logic        eof_seen;
	logic        single_byte;
	logic [38:0] tok_word;

	// token classes and the whole token as one word
	assign eof_seen    = tok_valid && (token_kind == K_EOF);
	assign single_byte = tok_valid && (token_kind inside {[K_LPAREN:K_AT], K_UNKNOWN});
	assign tok_word    = {token_kind, token_start, token_length, last_of_run};

	// only defined kinds leave the block
	`STT_CHECK(a_kind_range, tok_valid |-> (token_kind <= K_UNTERM), "token kind out of range")

	// end of file closes its run and has no length
	`STT_CHECK(a_eof_shape, eof_seen |-> (last_of_run && token_length == 16'd0), "bad eof token")

	// punctuation and unknown bytes are one byte long
	`STT_CHECK(a_single_byte, single_byte |-> (token_length == 16'd1), "bad single-byte token")

	// a stalled token holds
	`STT_CHECK_NEXT(a_stall_hold, tok_valid && tok_stall, tok_valid && $stable(tok_word), "stalled token changed")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tok_valid    (tok_valid),
	.tok_stall    (tok_stall),
	.token_kind   (token_kind),
	.token_start  (token_start),
	.token_length (token_length),
	.last_of_run  (last_of_run)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for source_text_tokenizer. Source bytes and end markers
// go in with random gaps and token back-pressure; every token is checked
// against a behavioral lexer or a directed row. A directed table comes first,
// then random source fragments, each source closed by an end marker.
// ----------------------------------------------------------------------------

module tb;
	import stt_pkg::*;

	localparam int RANDOM_REQUESTS   = 180;
	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int DRAIN_CYCLES      = 20;
	localparam int MAX_REPORTS       = 10;

	typedef enum logic [3:0] {
		LX_IDLE, LX_INT, LX_INT_DOT, LX_FLOAT, LX_WORD, LX_STR, LX_SLASH, LX_CMT, LX_CMT_STAR
	} lex_state_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		token_t     tok;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        src_valid;
	logic        src_stall;
	logic [7:0]  char_byte;
	logic        is_end;
	logic        tok_valid;
	logic        tok_stall;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	// behavioral lexer state
	lex_state_t  lx_state;
	logic [15:0] lx_pos;
	logic [15:0] lx_begin;
	logic [15:0] lx_dot;
	logic [47:0] lx_word;
	logic [2:0]  lx_count;

	token_t    step_tokens[$];
	token_t    expected_tokens[$];
	stim_row_t directed_rows[$];

	string keyword_list[13] = '{"fn", "let", "int", "float", "string", "use", "if", "else",
		"while", "ret", "for", "extern", "void"};

	bit calm;
	bit paused_once;
	int mismatch_count;
	int quiet_cycles;
	int requests_sent;

	source_text_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.char_byte    (char_byte),
		.is_end       (is_end),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- lexer

	function automatic logic [15:0] bump(logic [15:0] p);
		return (p == 16'hFFFF) ? p : p + 16'd1;
	endfunction

	function automatic logic [15:0] distance(logic [15:0] from, logic [15:0] to);
		return (to >= from) ? to - from : 16'd0;
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic kind_t punct_of(logic [7:0] c);
		kind_t k;
		case (c)
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			",":     k = K_COMMA;
			".":     k = K_DOT;
			"-":     k = K_MINUS;
			"+":     k = K_PLUS;
			";":     k = K_SEMI;
			":":     k = K_COLON;
			"*":     k = K_STAR;
			"<":     k = K_LESS;
			">":     k = K_GREATER;
			"=":     k = K_EQUAL;
			"!":     k = K_BANG;
			"]":     k = K_RBRACKET;
			"[":     k = K_LBRACKET;
			"@":     k = K_AT;
			default: k = K_NOT_PUNCT;
		endcase
		return k;
	endfunction

	// word bytes are kept right-justified, so a literal compares directly
	function automatic kind_t word_kind();
		kind_t k;
		k = K_IDENT;
		if (lx_count <= 3'd6) begin
			case (lx_word)
				"fn":     k = K_KW_FN;
				"let":    k = K_KW_LET;
				"int":    k = K_KW_INT;
				"float":  k = K_KW_FLOAT;
				"string": k = K_KW_STRING;
				"use":    k = K_KW_USE;
				"if":     k = K_KW_IF;
				"else":   k = K_KW_ELSE;
				"while":  k = K_KW_WHILE;
				"ret":    k = K_KW_RET;
				"for":    k = K_KW_FOR;
				"extern": k = K_KW_EXTERN;
				"void":   k = K_KW_VOID;
				default:  k = K_IDENT;
			endcase
		end
		return k;
	endfunction

	function automatic void emit(kind_t k, logic [15:0] s, logic [15:0] l);
		token_t t;
		t.kind   = k;
		t.start  = s;
		t.length = l;
		t.last   = 1'b0;
		if (step_tokens.size() < MAX_TOKENS)
			step_tokens.push_back(t);
	endfunction

	function automatic void lex_clear();
		lx_state = LX_IDLE;
		lx_pos   = 16'd0;
		lx_begin = 16'd0;
		lx_dot   = 16'd0;
		lx_word  = 48'd0;
		lx_count = 3'd0;
	endfunction

	// a byte seen with no token pending
	function automatic void lex_idle_byte(logic [7:0] c, logic [15:0] p);
		kind_t pk;
		pk = punct_of(c);
		lx_state = LX_IDLE;
		if (pk != K_NOT_PUNCT) begin
			emit(pk, p, 16'd1);
		end else if (c == CH_SLASH) begin
			lx_state = LX_SLASH;
			lx_begin = p;
		end else if ((c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB)) begin
			// separator, nothing to do
		end else if (is_num(c)) begin
			lx_state = LX_INT;
			lx_begin = p;
		end else if (is_alpha(c)) begin
			lx_state = LX_WORD;
			lx_begin = p;
			lx_word  = {40'd0, c};
			lx_count = 3'd1;
		end else if (c == CH_QUOTE) begin
			lx_state = LX_STR;
			lx_begin = bump(p);
		end else begin
			emit(K_UNKNOWN, p, 16'd1);
		end
	endfunction

	// tokens caused by one request land in step_tokens
	function automatic void lex_request(logic [7:0] c, logic fin);
		logic [15:0] p;
		p = lx_pos;
		step_tokens.delete();
		if (fin) begin
			// flush the pending token, then end of file and back to offset 0
			case (lx_state)
				LX_INT:     emit(K_INT, lx_begin, distance(lx_begin, p));
				LX_INT_DOT: begin
					emit(K_INT, lx_begin, distance(lx_begin, lx_dot));
					emit(K_DOT, lx_dot, 16'd1);
				end
				LX_FLOAT:   emit(K_FLOAT, lx_begin, distance(lx_begin, p));
				LX_WORD:    emit(word_kind(), lx_begin, distance(lx_begin, p));
				LX_STR:     emit(K_UNTERM, lx_begin, distance(lx_begin, p));
				LX_SLASH:   emit(K_SLASH, lx_begin, 16'd1);
				default: begin
				end
			endcase
			emit(K_EOF, p, 16'd0);
			lex_clear();
		end else begin
			case (lx_state)
				LX_INT: begin
					if (c == CH_DOT) begin
						lx_state = LX_INT_DOT;
						lx_dot   = p;
					end else if (!is_num(c)) begin
						emit(K_INT, lx_begin, distance(lx_begin, p));
						lex_idle_byte(c, p);
					end
				end
				LX_INT_DOT: begin
					if (is_num(c)) begin
						lx_state = LX_FLOAT;
					end else begin
						emit(K_INT, lx_begin, distance(lx_begin, lx_dot));
						emit(K_DOT, lx_dot, 16'd1);
						lex_idle_byte(c, p);
					end
				end
				LX_FLOAT: begin
					if (!is_num(c)) begin
						emit(K_FLOAT, lx_begin, distance(lx_begin, p));
						lex_idle_byte(c, p);
					end
				end
				LX_WORD: begin
					if (is_alpha(c) || is_num(c)) begin
						if (lx_count < 3'd6)
							lx_word = {lx_word[39:0], c};
						if (lx_count <= 3'd6)
							lx_count = lx_count + 3'd1;
					end else begin
						emit(word_kind(), lx_begin, distance(lx_begin, p));
						lex_idle_byte(c, p);
					end
				end
				LX_STR: begin
					if (c == CH_QUOTE) begin
						emit(K_STRING, lx_begin, distance(lx_begin, p));
						lx_state = LX_IDLE;
					end
				end
				LX_SLASH: begin
					if (c == CH_STAR) begin
						lx_state = LX_CMT;
					end else begin
						emit(K_SLASH, lx_begin, 16'd1);
						lex_idle_byte(c, p);
					end
				end
				LX_CMT: begin
					if (c == CH_STAR)
						lx_state = LX_CMT_STAR;
				end
				LX_CMT_STAR: begin
					if (c == CH_SLASH)
						lx_state = LX_IDLE;
					else if (c != CH_STAR)
						lx_state = LX_CMT;
				end
				default: lex_idle_byte(c, p);
			endcase
			lx_pos = bump(p);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	// idle length: mostly none or short, now and then long
	function automatic int pick_idle(int floor_len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return floor_len;
		else if (r < 90)
			return floor_len + $urandom_range(1, 3);
		else if (r < 97)
			return floor_len + $urandom_range(4, 12);
		return floor_len + $urandom_range(30, 60);
	endfunction

	function automatic logic [7:0] rand_word_start();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'h61 + 8'(r);
		else if (r < 52)
			return 8'h41 + 8'(r - 26);
		return 8'h5F;
	endfunction

	function automatic logic [7:0] rand_word_byte();
		if ($urandom_range(0, 3) == 0)
			return 8'h30 + 8'($urandom_range(0, 9));
		return rand_word_start();
	endfunction

	function automatic void add_row(logic [7:0] ch, logic fin, logic typed = 1'b0,
			kind_t k = K_EOF, logic [15:0] s = 16'd0, logic [15:0] l = 16'd0);
		stim_row_t row;
		row.ch         = ch;
		row.fin        = fin;
		row.typed      = typed;
		row.tok.kind   = k;
		row.tok.start  = s;
		row.tok.length = l;
		row.tok.last   = 1'b1;
		directed_rows.push_back(row);
	endfunction

	// one request: optional gap, hold until taken, then record the tokens it causes
	task automatic push_byte(input logic [7:0] b, input logic fin, input logic typed = 1'b0,
			input token_t typed_tok = '0);
		int gap;
		token_t t;
		gap = calm ? 0 : pick_idle(0);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		char_byte <= b;
		is_end    <= fin;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		requests_sent++;
		lex_request(b, fin);
		if (typed) begin
			typed_tok.last = 1'b1;
			expected_tokens.push_back(typed_tok);
		end else begin
			foreach (step_tokens[i]) begin
				t      = step_tokens[i];
				t.last = (i == step_tokens.size() - 1);
				expected_tokens.push_back(t);
			end
		end
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0);
	endtask

	task automatic send_digits(input int n);
		repeat (n) push_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
	endtask

	// one well-formed fragment most of the time, some noise and broken ones
	task automatic send_snippet();
		int pick;
		int n;
		int i;
		string w;
		string marks;
		logic [7:0] b;
		marks = "(){},.-+;:*<>=!][@";
		pick = $urandom_range(0, 11);
		case (pick)
			0: send_text(keyword_list[$urandom_range(0, 12)]);
			1: begin
				// near miss: keyword with one byte more or one less
				w = keyword_list[$urandom_range(0, 12)];
				if ($urandom_range(0, 1) == 0) begin
					send_text(w);
					push_byte(rand_word_byte(), 1'b0);
				end else begin
					send_text(w.substr(0, w.len() - 2));
				end
			end
			2: begin
				n = $urandom_range(1, 10);
				push_byte(rand_word_start(), 1'b0);
				for (i = 1; i < n; i++)
					push_byte(rand_word_byte(), 1'b0);
			end
			3: send_digits($urandom_range(1, 5));
			4: begin
				send_digits($urandom_range(1, 4));
				push_byte(CH_DOT, 1'b0);
				send_digits($urandom_range(1, 4));
			end
			5: begin
				// dot with no fractional digit
				send_digits($urandom_range(1, 3));
				push_byte(CH_DOT, 1'b0);
				if ($urandom_range(0, 1) == 0)
					push_byte(($urandom_range(0, 1) == 0) ? rand_word_start() : CH_SPACE, 1'b0);
			end
			6: begin
				push_byte(CH_QUOTE, 1'b0);
				n = $urandom_range(0, 8);
				for (i = 0; i < n; i++) begin
					b = 8'($urandom_range(0, 255));
					push_byte((b == CH_QUOTE) ? 8'h00 : b, 1'b0);
				end
				if ($urandom_range(0, 5) != 0)
					push_byte(CH_QUOTE, 1'b0);
			end
			7: begin
				push_byte(CH_SLASH, 1'b0);
				push_byte(CH_STAR, 1'b0);
				n = $urandom_range(0, 6);
				for (i = 0; i < n; i++) begin
					case ($urandom_range(0, 2))
						0:       push_byte(CH_STAR, 1'b0);
						1:       push_byte(CH_SLASH, 1'b0);
						default: push_byte(8'($urandom_range(0, 255)), 1'b0);
					endcase
				end
				if ($urandom_range(0, 5) != 0) begin
					push_byte(CH_STAR, 1'b0);
					push_byte(CH_SLASH, 1'b0);
				end
			end
			8:  push_byte(marks[$urandom_range(0, marks.len() - 1)], 1'b0);
			9:  push_byte(CH_SLASH, 1'b0);
			10: push_byte(8'($urandom_range(0, 255)), 1'b0);
			default: push_byte(CH_SPACE, 1'b0);
		endcase
		// separator, or none so fragments run together
		case ($urandom_range(0, 3))
			0:       push_byte(CH_SPACE, 1'b0);
			1:       push_byte(CH_NL, 1'b0);
			2:       push_byte(CH_TAB, 1'b0);
			default: begin
			end
		endcase
	endtask

	// directed table: fixed rows are simple enough to read off by hand
	function automatic void build_directed_rows();
		add_row("(", 1'b0, 1'b1, K_LPAREN, 16'd0, 16'd1);
		add_row(8'h01, 1'b0, 1'b1, K_UNKNOWN, 16'd1, 16'd1);
		add_row(8'hFF, 1'b0, 1'b1, K_UNKNOWN, 16'd2, 16'd1);
		add_row(8'h00, 1'b0, 1'b1, K_UNKNOWN, 16'd3, 16'd1);
		// integer, dot with no fraction, then an identifier
		add_row("1", 1'b0);
		add_row("2", 1'b0);
		add_row(".", 1'b0);
		add_row("x", 1'b0);
		// a lone slash before an identifier, then a slash that opens a comment
		add_row("/", 1'b0);
		add_row("a", 1'b0);
		add_row("/", 1'b0);
		// comment whose opening star cannot close it, byte zero inside
		add_row("*", 1'b0);
		add_row("/", 1'b0);
		add_row(8'h00, 1'b0);
		add_row("*", 1'b0);
		add_row("/", 1'b0);
		// float, then a string left open with byte zero inside
		add_row("3", 1'b0);
		add_row(".", 1'b0);
		add_row("5", 1'b0);
		add_row(CH_QUOTE, 1'b0);
		add_row(8'h00, 1'b0);
		add_row(8'h00, 1'b1);
		// end right after end, then a slash flushed by the end marker
		add_row(8'hFF, 1'b1, 1'b1, K_EOF, 16'd0, 16'd0);
		add_row("/", 1'b0);
		add_row(8'h00, 1'b1);
	endfunction

	initial begin : stimulus
		int random_base;
		arst_n         = 1'b0;
		src_valid      = 1'b0;
		char_byte      = 8'h00;
		is_end         = 1'b0;
		calm           = 1'b0;
		paused_once    = 1'b0;
		mismatch_count = 0;
		requests_sent  = 0;
		lex_clear();
		build_directed_rows();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			push_byte(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].typed,
				directed_rows[i].tok);

		// random sources, each closed by an end marker
		random_base = requests_sent;
		while (requests_sent - random_base < RANDOM_REQUESTS) begin
			calm = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(2, 12)) send_snippet();
			if (!paused_once && (requests_sent - random_base >= RANDOM_REQUESTS / 2)) begin
				// hold off until every token so far has come out
				paused_once = 1'b1;
				src_valid <= 1'b0;
				do @(negedge clk); while (expected_tokens.size() != 0);
			end
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		end

		// drain
		src_valid <= 1'b0;
		calm = 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_tokens.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// token sink: random stalls, none while calm
	initial begin : token_sink
		int hold;
		bit stall_now;
		tok_stall = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				tok_stall <= 1'b0;
				hold = 0;
			end else if (hold > 1) begin
				hold = hold - 1;
			end else begin
				stall_now = ($urandom_range(0, 2) == 0);
				hold = stall_now ? pick_idle(1) : $urandom_range(1, 12);
				tok_stall <= stall_now;
			end
		end
	end

	// ---------------------------------------------------------------- checking

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// compare each accepted token with the oldest expected one
	always @(posedge clk) begin : token_check
		token_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_tokens.size() == 0) begin
				note_mismatch($sformatf("unexpected token kind %0d start %0d len %0d last %0b",
					token_kind, token_start, token_length, last_of_run));
			end else begin
				want = expected_tokens.pop_front();
				if (token_kind !== want.kind || token_start !== want.start ||
						token_length !== want.length || last_of_run !== want.last)
					note_mismatch($sformatf(
						"token exp kind %0d start %0d len %0d last %0b, got %0d %0d %0d %0b",
						want.kind, want.start, want.length, want.last,
						token_kind, token_start, token_length, last_of_run));
			end
		end
	end

	// watchdog: ends a run in which nothing moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
